FILE: rtl/core/tes_pkg.sv
// timed event sequencer: shared types and constants
// no dependencies; compiled first
`default_nettype none

package tes_pkg;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_START  = 2'd2,
    REQ_PAUSE  = 2'd3
  } req_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } state_e;

  typedef struct packed {
    logic [31:0]        id;
    logic [3:0]         code;
    logic signed [15:0] data;
  } event_t;

  typedef struct packed {
    logic latch;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic raise;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tes_if.sv
// timed event sequencer: request, event and config channel interfaces
// no dependencies
`default_nettype none

interface tes_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [3:0]         entry_index;
  logic [31:0]        event_id;
  logic [3:0]         event_type;
  logic signed [15:0] event_data;
  logic [31:0]        delay_ms;
  logic               pause_on;

  modport source (
    output valid, req_type, entry_index, event_id, event_type, event_data, delay_ms,
           pause_on,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, event_id, event_type, event_data, delay_ms,
           pause_on,
    output ready
  );
endinterface

interface tes_evt_if;
  logic               valid;
  logic               ready;
  logic [31:0]        out_id;
  logic [3:0]         out_type;
  logic signed [15:0] out_data;
  logic [3:0]         out_index;

  modport source (output valid, out_id, out_type, out_data, out_index, input ready);
  modport sink   (input  valid, out_id, out_type, out_data, out_index, output ready);
endinterface

interface tes_cfg_if;
  logic valid;
  logic ready;
  logic perpetual;

  modport source (output valid, perpetual, input ready);
  modport sink   (input  valid, perpetual, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tes_ctrl.sv
// timed event sequencer: controller state machine
// depends on tes_pkg
`default_nettype none

module tes_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  tes_pkg::dp_status_t    status_i,
  output logic                   in_ready_o,
  output tes_pkg::ctrl_cmd_t     cmd_o
);
  import tes_pkg::*;

  state_e state_q, state_d;
  logic   stall;

  // a raise has to wait while the result register still holds an untaken beat
  assign stall = status_i.raise && status_i.out_busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL: if (!stall) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.latch  = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_EVAL: cmd_o.commit = !stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tes_datapath.sv
// timed event sequencer: event table memories, sequence state, result register
// depends on tes_pkg
`default_nettype none

module tes_datapath #(
  parameter int MAX_EVENTS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  tes_pkg::ctrl_cmd_t    cmd_i,
  output tes_pkg::dp_status_t   status_o,
  input  wire [1:0]             req_type_i,
  input  wire [3:0]             entry_index_i,
  input  wire [31:0]            event_id_i,
  input  wire [3:0]             event_type_i,
  input  wire signed [15:0]     event_data_i,
  input  wire [31:0]            delay_ms_i,
  input  wire                   pause_on_i,
  input  wire                   cfg_we_i,
  input  wire                   cfg_perpetual_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [31:0]           out_id_o,
  output logic [3:0]            out_type_o,
  output logic signed [15:0]    out_data_o,
  output logic [3:0]            out_index_o
);
  import tes_pkg::*;

  localparam int IW = $clog2(MAX_EVENTS);
  localparam int CW = $clog2(MAX_EVENTS + 1);

  // event table
  event_t      ev_mem  [MAX_EVENTS];
  logic [31:0] dly_mem [MAX_EVENTS];
  event_t      ev_rd_q;
  logic [31:0] dly_rd_q;

  // latched request
  req_e        req_q;
  logic [3:0]  idx_q;
  event_t      ent_q;
  logic [31:0] dly_q;
  logic        pause_q;

  // sequence state
  logic [CW-1:0] count_q;
  logic [IW-1:0] cur_q;
  logic [31:0]   elapsed_q;
  logic          running_q;
  logic          paused_q;
  logic          perpetual_q;

  // result register
  logic          out_valid_q;
  event_t        out_ev_q;
  logic [3:0]    out_idx_q;

  logic [CW-1:0]   cur_inc;
  logic            last_c;
  logic            cur_bad;
  logic [IW-1:0]   nxt_c;
  logic [IW+3:0]   in_idx_wide;
  logic [IW+3:0]   q_idx_wide;
  logic [IW-1:0]   rd_addr;
  logic [CW+3:0]   count_wide;
  logic [CW+3:0]   start_wide;
  logic            start_ok;
  logic            full;
  logic [31:0]     el_inc;
  logic            due;
  logic            raise_c;
  logic [IW-1:0]   raise_idx;
  logic [IW+3:0]   raise_wide;
  logic            tick_live;

  assign cur_inc     = CW'(cur_q) + CW'(1);
  assign last_c      = cur_inc >= count_q;
  assign cur_bad     = CW'(cur_q) >= count_q;
  assign nxt_c       = last_c ? '0 : cur_inc[IW-1:0];
  assign in_idx_wide = {{IW{1'b0}}, entry_index_i};
  assign q_idx_wide  = {{IW{1'b0}}, idx_q};
  assign rd_addr     = (req_e'(req_type_i) == REQ_START) ? in_idx_wide[IW-1:0] : nxt_c;
  assign count_wide  = {4'b0000, count_q};
  assign start_wide  = {{CW{1'b0}}, idx_q};
  assign start_ok    = start_wide < count_wide;
  assign full        = count_q >= CW'(MAX_EVENTS);
  assign el_inc      = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;
  assign due         = el_inc >= dly_rd_q;
  assign tick_live   = running_q && !paused_q;

  always_comb begin
    raise_c   = 1'b0;
    raise_idx = nxt_c;
    case (req_q)
      REQ_TICK: raise_c = tick_live && !cur_bad && due && (!last_c || perpetual_q);
      REQ_START: begin
        raise_c   = start_ok;
        raise_idx = q_idx_wide[IW-1:0];
      end
      default: ;
    endcase
  end

  assign raise_wide = {4'b0000, raise_idx};

  assign status_o.raise    = raise_c;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  // table write and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ev_rd_q  <= ev_mem[rd_addr];
      dly_rd_q <= dly_mem[cur_q];
    end
    if (cmd_i.commit && req_q == REQ_APPEND && !full) begin
      ev_mem[count_q[IW-1:0]]  <= ent_q;
      dly_mem[count_q[IW-1:0]] <= dly_q;
    end
  end

  // request payload, and the raised event payload on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      idx_q     <= entry_index_i;
      ent_q.id   <= event_id_i;
      ent_q.code <= event_type_i;
      ent_q.data <= event_data_i;
      dly_q     <= delay_ms_i;
      pause_q   <= pause_on_i;
    end
    if (cmd_i.commit && raise_c) begin
      out_ev_q  <= ev_rd_q;
      out_idx_q <= raise_wide[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q       <= REQ_TICK;
      count_q     <= '0;
      cur_q       <= '0;
      elapsed_q   <= '0;
      running_q   <= 1'b0;
      paused_q    <= 1'b0;
      perpetual_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) perpetual_q <= cfg_perpetual_i;
      if (cmd_i.latch) req_q <= req_e'(req_type_i);
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.commit) begin
        if (raise_c) begin
          cur_q       <= raise_idx;
          elapsed_q   <= '0;
          running_q   <= 1'b1;
          out_valid_q <= 1'b1;
        end else begin
          case (req_q)
            REQ_TICK: begin
              if (tick_live) begin
                if (cur_bad) begin
                  running_q <= 1'b0;
                end else begin
                  elapsed_q <= el_inc;
                  if (due && last_c && !perpetual_q) running_q <= 1'b0;
                end
              end
            end
            REQ_APPEND: if (!full) count_q <= count_q + CW'(1);
            REQ_PAUSE:  paused_q <= pause_q;
            default: ;
          endcase
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_ev_q.id;
  assign out_type_o  = out_ev_q.code;
  assign out_data_o  = out_ev_q.data;
  assign out_index_o = out_idx_q;

endmodule

`default_nettype wire

FILE: rtl/core/timed_event_sequencer.sv
// timed event sequencer top level: controller, datapath and channel ports
// order: a request beat is accepted, the next cycle evaluates it; a raised event is
// presented in the result register when evaluation commits; a new beat is taken only
// after the last one is evaluated, with the registered table read between accept and
// evaluate; evaluation holds while a raised event meets an untaken result beat
// reset: asynchronous active low; table contents are left as they are, counters clear
`default_nettype none

module timed_event_sequencer #(
  parameter int MAX_EVENTS = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  tes_req_if.sink   req_i,
  tes_evt_if.source evt_o,
  tes_cfg_if.sink   cfg_i
);
  import tes_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // config register takes a write in any cycle
  assign cfg_i.ready = 1'b1;

  // controller: idle takes a request beat, evaluate commits it once the result
  // register can take a raised event
  tes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .status_i   (status),
    .in_ready_o (req_i.ready),
    .cmd_o      (cmd)
  );

  // datapath: event table, elapsed tick counter, running and pause flags,
  // and the output register for raised events
  tes_datapath #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (req_i.req_type),
    .entry_index_i   (req_i.entry_index),
    .event_id_i      (req_i.event_id),
    .event_type_i    (req_i.event_type),
    .event_data_i    (req_i.event_data),
    .delay_ms_i      (req_i.delay_ms),
    .pause_on_i      (req_i.pause_on),
    .cfg_we_i        (cfg_i.valid),
    .cfg_perpetual_i (cfg_i.perpetual),
    .out_valid_o     (evt_o.valid),
    .out_ready_i     (evt_o.ready),
    .out_id_o        (evt_o.out_id),
    .out_type_o      (evt_o.out_type),
    .out_data_o      (evt_o.out_data),
    .out_index_o     (evt_o.out_index)
  );

endmodule

`default_nettype wire

FILE: rtl/core/tes_checker.sv
// timed event sequencer: port-level assertions and their bind to the top level
// depends on the top level ports only
`default_nettype none

module tes_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        req_valid_i,
  input wire        req_ready_i,
  input wire        evt_valid_i,
  input wire        evt_ready_i,
  input wire [31:0] evt_id_i,
  input wire [3:0]  evt_index_i
);

  // result beat stays up until taken
  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=> evt_valid_i)
    else $error("result beat dropped before taken");

  // stalled result payload holds
  a_evt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=> $stable(evt_id_i) && $stable(evt_index_i))
    else $error("result payload changed while stalled");

  // a request beat is followed by evaluation, during which no new beat is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken during evaluation");

  // a new result appears only out of an evaluate cycle
  a_evt_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(evt_valid_i) |-> $past(!req_ready_i))
    else $error("result raised without a request under evaluation");

endmodule

bind timed_event_sequencer tes_checker u_tes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .evt_valid_i (evt_o.valid),
  .evt_ready_i (evt_o.ready),
  .evt_id_i    (evt_o.out_id),
  .evt_index_i (evt_o.out_index)
);

`default_nettype wire

FILE: tb/tb_top.sv
// testbench for the timed event sequencer: directed table, then random request traffic
// checked against an in-bench model of the event table; depends on tes_pkg, the three
// channel interfaces in tes_if.sv and the timed_event_sequencer top level
`default_nettype none

module tb_top;
  import tes_pkg::*;

  localparam int MAX_EVENTS   = 16;
  localparam int SETTLE       = 4;        // settle wait after the last owed event so the pipe empties
  localparam int LONG_HOLD    = 80;       // receiver back-pressure stretch, in cycles
  localparam int RUN_LIMIT    = 2000000;  // hard stop, in time units

  // what the scoreboard does with the result of one request beat
  typedef enum logic [1:0] {
    CHK_PRED,  // expectation comes from the in-bench model
    CHK_NONE,  // typed in: no event may come out
    CHK_EVT    // typed in: exactly this event comes out
  } check_e;

  typedef struct packed {
    logic [31:0]        id;
    logic [3:0]         code;
    logic signed [15:0] data;
    logic [3:0]         index;
  } raised_t;

  typedef struct {
    req_e               kind;
    logic [3:0]         index;
    logic [31:0]        id;
    logic [3:0]         code;
    logic signed [15:0] data;
    logic [31:0]        wait_ms;
    logic               pause;
  } req_beat_t;

  typedef struct {
    req_beat_t beat;
    check_e    check;
    raised_t   want;
  } dir_row_t;

  localparam raised_t NO_EVT = '0;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  tes_req_if req_if ();
  tes_evt_if evt_if ();
  tes_cfg_if cfg_if ();

  timed_event_sequencer #(
    .MAX_EVENTS(MAX_EVENTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .evt_o (evt_if),
    .cfg_i (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // in-bench model of the sequencer: its own copy of table, counters and register
  // ---------------------------------------------------------------------------
  event_t      entry_tbl [MAX_EVENTS];
  logic [31:0] wait_tbl  [MAX_EVENTS];
  int unsigned n_entries;
  int unsigned cur_idx;
  logic [31:0] elapsed;
  logic        seq_running;
  logic        seq_paused;
  logic        perpetual_q;

  // events still owed by the block, oldest first
  raised_t pending_events [$];

  int     fail_count  = 0;
  bit     gaps_on     = 1'b0;  // random idle bursts on both channels
  bit     stall_hold  = 1'b0;  // asks the result sink for one long hold-off
  check_e beat_check  = CHK_PRED;
  raised_t beat_want  = '0;

  // jump to an entry: the counter clears and the entry goes out as an event
  function automatic void raise_entry_at(input int unsigned idx, output raised_t r);
    cur_idx     = idx;
    elapsed     = '0;
    seq_running = 1'b1;
    r = '{entry_tbl[idx].id, entry_tbl[idx].code, entry_tbl[idx].data, idx[3:0]};
  endfunction

  // apply one accepted request; returns 1 when it raises an event
  function automatic bit advance_sequencer(input req_beat_t b, output raised_t r);
    r = '0;
    case (b.kind)
      REQ_TICK: begin
        if (!seq_running || seq_paused) return 1'b0;
        if (cur_idx >= n_entries) begin
          seq_running = 1'b0;
          return 1'b0;
        end
        if (elapsed != '1) elapsed = elapsed + 32'd1;
        if (elapsed < wait_tbl[cur_idx]) return 1'b0;
        // last entry: wrap to the first one or stop where we are
        if (cur_idx + 1 >= n_entries) begin
          if (perpetual_q) begin
            raise_entry_at(0, r);
            return 1'b1;
          end
          seq_running = 1'b0;
          return 1'b0;
        end
        raise_entry_at(cur_idx + 1, r);
        return 1'b1;
      end
      REQ_APPEND: begin
        // a full table drops the append
        if (n_entries >= MAX_EVENTS) return 1'b0;
        entry_tbl[n_entries] = '{b.id, b.code, b.data};
        wait_tbl[n_entries]  = b.wait_ms;
        n_entries++;
        return 1'b0;
      end
      REQ_START: begin
        if (b.index >= n_entries) return 1'b0;
        raise_entry_at(b.index, r);
        return 1'b1;
      end
      default: begin
        seq_paused = b.pause;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: reset behavior, field extremes, every request and the corners
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [23] = '{
    // stopped after reset: tick and start on an empty table do nothing
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    '{'{REQ_START,  4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    '{'{REQ_PAUSE,  4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b1}, CHK_NONE, NO_EVT},
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    '{'{REQ_PAUSE,  4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    // two entries at opposite extremes: all-zero id, most negative data, no delay ...
    '{'{REQ_APPEND, 4'd0,  32'h0,        4'h0, 16'sh8000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    // ... and all-ones id and type, most positive data, two ticks of delay
    '{'{REQ_APPEND, 4'd15, 32'hFFFFFFFF, 4'hF, 16'sh7FFF, 32'd2,        1'b1}, CHK_NONE, NO_EVT},
    '{'{REQ_START,  4'd1,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0},
      CHK_EVT, '{32'hFFFFFFFF, 4'hF, 16'sh7FFF, 4'd1}},
    // start beyond the filled part of the table is ignored
    '{'{REQ_START,  4'd15, 32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    // delay met on the last entry, not perpetual: the sequence stops silently
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    '{'{REQ_START,  4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0},
      CHK_EVT, '{32'h0, 4'h0, 16'sh8000, 4'd0}},
    // paused ticks hold the counter
    '{'{REQ_PAUSE,  4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b1}, CHK_NONE, NO_EVT},
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    '{'{REQ_PAUSE,  4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT},
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_PRED, NO_EVT},
    // append while running, with the largest delay; it joins the running sequence
    '{'{REQ_APPEND, 4'd0,  32'hA5C33C5A, 4'h6, 16'shFB2E, 32'hFFFFFFFF, 1'b0}, CHK_NONE, NO_EVT},
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_PRED, NO_EVT},
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_PRED, NO_EVT},
    '{'{REQ_TICK,   4'd0,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_PRED, NO_EVT},
    // start while running restarts at the given entry
    '{'{REQ_START,  4'd1,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0},
      CHK_EVT, '{32'hFFFFFFFF, 4'hF, 16'sh7FFF, 4'd1}},
    // start exactly at the entry count is ignored
    '{'{REQ_START,  4'd3,  32'h0,        4'h0, 16'sh0000, 32'd0,        1'b0}, CHK_NONE, NO_EVT}
  };

  // ---------------------------------------------------------------------------
  // scoreboard: request beats feed the model, event beats are checked in order
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    req_beat_t b;
    raised_t   ev;
    raised_t   got;
    bit        hit;
    if (rst_ni) begin
      // requests first, so a same-cycle event could still find its expectation
      if (req_if.valid && req_if.ready) begin
        b = '{req_e'(req_if.req_type), req_if.entry_index, req_if.event_id,
              req_if.event_type, req_if.event_data, req_if.delay_ms, req_if.pause_on};
        hit = advance_sequencer(b, ev);
        case (beat_check)
          CHK_PRED: if (hit) pending_events.push_back(ev);
          CHK_EVT:  pending_events.push_back(beat_want);
          default:  ;
        endcase
      end
      if (evt_if.valid && evt_if.ready) begin
        got = '{evt_if.out_id, evt_if.out_type, evt_if.out_data, evt_if.out_index};
        if (pending_events.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected event, expected none, actual %h", $time, got);
        end else begin
          ev = pending_events.pop_front();
          check_field("out_id",    ev.id,    got.id);
          check_field("out_type",  ev.code,  got.code);
          check_field("out_data",  ev.data,  got.data);
          check_field("out_index", ev.index, got.index);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // event sink: random ready bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : event_sink
    evt_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_hold) begin
        // long stretch so the result register fills and the request side stalls
        evt_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        stall_hold = 1'b0;
        evt_if.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        evt_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        evt_if.ready <= 1'b1;
      end else begin
        evt_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side: all tasks start and end on a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_beat(input req_beat_t b, input check_e chk, input raised_t want);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= b.kind;
    req_if.entry_index <= b.index;
    req_if.event_id    <= b.id;
    req_if.event_type  <= b.code;
    req_if.event_data  <= b.data;
    req_if.delay_ms    <= b.wait_ms;
    req_if.pause_on    <= b.pause;
    beat_check = chk;
    beat_want  = want;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every owed event is out and the pipe is empty
  task automatic drain_sequencer();
    req_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_perpetual(input logic value);
    cfg_if.valid     <= 1'b1;
    cfg_if.perpetual <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    perpetual_q = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // mostly ticks, so started sequences run on; appends carry short delays so the
  // table keeps moving and wraps around when perpetual
  function automatic req_beat_t draw_request();
    req_beat_t   b;
    int unsigned pick;
    pick      = $urandom_range(0, 99);
    b.index   = 4'($urandom);
    b.id      = $urandom;
    b.code    = 4'($urandom);
    b.data    = 16'($urandom);
    b.wait_ms = $urandom;
    b.pause   = 1'($urandom);
    if (pick < 60) begin
      b.kind = REQ_TICK;
    end else if (pick < 75) begin
      b.kind = REQ_START;
      // mostly a filled entry, now and then any index
      if (n_entries != 0 && $urandom_range(0, 4) != 0)
        b.index = 4'($urandom_range(0, n_entries - 1));
    end else if (pick < 85) begin
      b.kind    = REQ_APPEND;
      b.wait_ms = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
    end else begin
      b.kind  = REQ_PAUSE;
      b.pause = ($urandom_range(0, 3) == 0);
    end
    return b;
  endfunction

  task automatic run_random(input int n_items, input int hold_at, input int drain_at);
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) stall_hold = 1'b1;
      if (i == drain_at) drain_sequencer();
      send_beat(draw_request(), CHK_PRED, NO_EVT);
    end
  endtask

  initial begin : stimulus
    n_entries   = 0;
    cur_idx     = 0;
    elapsed     = '0;
    seq_running = 1'b0;
    seq_paused  = 1'b0;
    perpetual_q = 1'b0;

    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_TICK;
    req_if.entry_index = '0;
    req_if.event_id    = '0;
    req_if.event_type  = '0;
    req_if.event_data  = '0;
    req_if.delay_ms    = '0;
    req_if.pause_on    = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.perpetual   = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    write_perpetual(1'b0);
    gaps_on = 1'b1;
    for (int r = 0; r < $size(dir_rows); r++)
      send_beat(dir_rows[r].beat, dir_rows[r].check, dir_rows[r].want);

    // non-perpetual: the table fills up here and later appends are dropped
    run_random(160, -1, -1);
    drain_sequencer();

    // perpetual, with one long receiver hold-off while requests keep coming
    write_perpetual(1'b1);
    run_random(160, 40, -1);
    drain_sequencer();

    // back to one-shot, with a mid-run pause until all events are out
    write_perpetual(1'b0);
    run_random(150, -1, 75);
    drain_sequencer();

    // perpetual again at full rate, no idling on either side
    write_perpetual(1'b1);
    gaps_on = 1'b0;
    run_random(160, -1, -1);
    drain_sequencer();

    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: timed_event_sequencer.f
rtl/core/tes_pkg.sv
rtl/core/tes_if.sv
rtl/core/tes_ctrl.sv
rtl/core/tes_datapath.sv
rtl/core/timed_event_sequencer.sv
rtl/core/tes_checker.sv
tb/tb_top.sv
